// File: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; compile first.
package i2cm_pkg;

  localparam int unsigned RegWidth = 8;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [RegWidth-1:0] PhaseDelayReset = 8'd2;
  localparam logic [RegWidth-1:0] AckPollReset = 8'd100;
  localparam logic [RegWidth-1:0] PollMax = 8'hFF;

  typedef enum logic [0:0] {
    REG_PHASE_DELAY = 1'b0,
    REG_ACK_POLL    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STA   = 4'd1,
    PH_STB   = 4'd2,
    PH_WBIT  = 4'd3,
    PH_WHI   = 4'd4,
    PH_WLO   = 4'd5,
    PH_WACK  = 4'd6,
    PH_WACKL = 4'd7,
    PH_RPRE  = 4'd8,
    PH_RHI   = 4'd9,
    PH_RLO   = 4'd10,
    PH_RACKH = 4'd11,
    PH_RACKL = 4'd12,
    PH_SPA   = 4'd13,
    PH_SPB   = 4'd14,
    PH_SPC   = 4'd15
  } phase_t;

  typedef struct packed {
    logic       sda_level;
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
  } tick_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] rx_byte;
  } result_t;

endpackage

// File: rtl/i2cm_stream_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Used with i2cm_pkg types by the engine top level.
interface i2cm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/i2c_master_byte_engine.sv
// Open-drain I2C master engine: one tick per transaction in, one result out.
// Depends on i2cm_pkg and i2cm_stream_if.

// One input transaction is one bus tick; the engine takes one every clock cycle
// unless the result sink stalls (a rate set by the single state-update stage);
// the result register gives its result in the next cycle and decouples a stalled
// sink. Commands (start, write, read, stop) are taken only when idle; each bus
// phase lasts phase_delay_ticks ticks (0 acts as 1), but write ACK polling then
// resamples every tick and fails after ack_poll_limit high samples (0 acts as 1).
module i2c_master_byte_engine (
  input  logic                        clk,
  input  logic                        rst,
  i2cm_stream_if.sink                 tick,
  i2cm_stream_if.source               result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [i2cm_pkg::RegWidth-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic [RegWidth-1:0] phase_delay_ticks;
  logic [RegWidth-1:0] ack_poll_limit;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shifter, shifter_next;
  logic [7:0] delay_count, delay_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_low_reg, scl_low_reg_next;
  logic       sda_low_reg, sda_low_reg_next;
  logic       ack_flag, ack_flag_next;
  logic       ack_to_send, ack_to_send_next;
  logic [7:0] rx_last, rx_last_next;
  logic       done_next;

  logic       out_valid;
  result_t    out_data;

  logic       accept;
  tick_t      t;
  logic [7:0] delay_eff, poll_lim;

  assign tick.ready     = !out_valid || result.ready;
  assign accept         = tick.valid && tick.ready;
  assign t              = tick.payload;
  assign result.valid   = out_valid;
  assign result.payload = out_data;
  assign delay_eff      = (phase_delay_ticks == '0) ? 8'd1 : phase_delay_ticks;
  assign poll_lim       = (ack_poll_limit == '0) ? 8'd1 : ack_poll_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_delay_ticks <= PhaseDelayReset;
      ack_poll_limit    <= AckPollReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PHASE_DELAY: phase_delay_ticks <= cfg_data;
        REG_ACK_POLL:    ack_poll_limit    <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] sh;
    logic [3:0] bc;
    logic [7:0] pc;
    phase_next       = phase;
    bit_count_next   = bit_count;
    shifter_next     = shifter;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    scl_low_reg_next = scl_low_reg;
    sda_low_reg_next = sda_low_reg;
    ack_flag_next    = ack_flag;
    ack_to_send_next = ack_to_send;
    rx_last_next     = rx_last;
    done_next        = 1'b0;
    sh = shifter << 1;
    bc = bit_count + 4'd1;
    pc = (poll_count < PollMax) ? poll_count + 8'd1 : poll_count;

    if (phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        bit_count_next   = '0;
        delay_count_next = delay_eff;
        case (mode_t'(t.mode))
          MODE_START: begin
            phase_next       = PH_STA;
            sda_low_reg_next = 1'b1;
          end
          MODE_WRITE: begin
            shifter_next     = t.tx_byte;
            phase_next       = PH_WBIT;
            scl_low_reg_next = 1'b1;
            sda_low_reg_next = !t.tx_byte[7];
          end
          MODE_READ: begin
            shifter_next     = '0;
            ack_to_send_next = t.send_ack;
            phase_next       = PH_RPRE;
            scl_low_reg_next = 1'b1;
            sda_low_reg_next = 1'b0;
          end
          default: begin
            phase_next       = PH_SPA;
            scl_low_reg_next = 1'b1;
            sda_low_reg_next = 1'b1;
          end
        endcase
      end
    end else if (delay_count > 8'd1) begin
      delay_count_next = delay_count - 8'd1;
    end else begin
      delay_count_next = delay_eff;
      case (phase)
        PH_STA: begin
          phase_next = PH_STB; scl_low_reg_next = 1'b1; sda_low_reg_next = 1'b1;
        end
        PH_WBIT: begin
          phase_next = PH_WHI; scl_low_reg_next = 1'b0;
        end
        PH_WHI: begin
          phase_next = PH_WLO; scl_low_reg_next = 1'b1;
        end
        PH_WLO: begin
          shifter_next   = sh;
          bit_count_next = bc;
          scl_low_reg_next = 1'b1;
          if (bc >= 4'(BitsPerByte)) begin
            poll_count_next  = '0;
            phase_next       = PH_WACK;
            scl_low_reg_next = 1'b0;
            sda_low_reg_next = 1'b0;
          end else begin
            phase_next       = PH_WBIT;
            sda_low_reg_next = !sh[7];
          end
        end
        PH_WACK: begin
          if (!t.sda_level) begin
            ack_flag_next = 1'b1;
            phase_next = PH_WACKL; scl_low_reg_next = 1'b1; sda_low_reg_next = 1'b0;
          end else begin
            poll_count_next = pc;
            if (pc >= poll_lim) begin
              ack_flag_next = 1'b0;
              phase_next = PH_WACKL; scl_low_reg_next = 1'b1; sda_low_reg_next = 1'b0;
            end else begin
              delay_count_next = '0;
            end
          end
        end
        PH_RPRE: begin
          phase_next = PH_RHI; scl_low_reg_next = 1'b0; sda_low_reg_next = 1'b0;
        end
        PH_RHI: begin
          shifter_next = {shifter[6:0], t.sda_level};
          phase_next = PH_RLO; scl_low_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        end
        PH_RLO: begin
          bit_count_next = bc;
          if (bc >= 4'(BitsPerByte)) begin
            phase_next = PH_RACKH; scl_low_reg_next = 1'b0;
            sda_low_reg_next = ack_to_send;
          end else begin
            phase_next = PH_RPRE; scl_low_reg_next = 1'b1; sda_low_reg_next = 1'b0;
          end
        end
        PH_RACKH: begin
          phase_next = PH_RACKL; scl_low_reg_next = 1'b1;
        end
        PH_SPA: begin
          phase_next = PH_SPB; scl_low_reg_next = 1'b0; sda_low_reg_next = 1'b1;
        end
        PH_SPB: begin
          phase_next = PH_SPC; scl_low_reg_next = 1'b0; sda_low_reg_next = 1'b0;
        end
        default: begin
          // end of start, write ACK, read ACK or stop
          if (phase == PH_RACKL) rx_last_next = shifter;
          phase_next       = PH_IDLE;
          delay_count_next = '0;
          done_next        = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shifter     <= '0;
      delay_count <= '0;
      poll_count  <= '0;
      scl_low_reg <= 1'b0;
      sda_low_reg <= 1'b0;
      ack_flag    <= 1'b0;
      ack_to_send <= 1'b0;
      rx_last     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shifter     <= shifter_next;
        delay_count <= delay_count_next;
        poll_count  <= poll_count_next;
        scl_low_reg <= scl_low_reg_next;
        sda_low_reg <= sda_low_reg_next;
        ack_flag    <= ack_flag_next;
        ack_to_send <= ack_to_send_next;
        rx_last     <= rx_last_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.scl_drive_low <= scl_low_reg_next;
      out_data.sda_drive_low <= sda_low_reg_next;
      out_data.busy_res      <= (phase_next != PH_IDLE);
      out_data.done_res      <= done_next;
      out_data.ack_received  <= ack_flag_next;
      out_data.rx_byte       <= rx_last_next;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for i2c_master_byte_engine: drives bus ticks with commands, predicts
// every per-tick output in a tick-level copy of the engine and checks each one.
// Depends on i2cm_pkg, i2cm_stream_if and the engine RTL.
module tb;
  import i2cm_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomTicks = 150;
  localparam int MaxReports = 10;
  localparam int PressureHold = 300;

  typedef enum int {
    SDA_RANDOM,
    SDA_HIGH,
    SDA_LOW
  } sda_drive_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [RegWidth-1:0] cfg_data;

  i2cm_stream_if #(.T(tick_t)) tick_ch ();
  i2cm_stream_if #(.T(result_t)) res_ch ();

  i2c_master_byte_engine uut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // engine copy
  logic [7:0] cfg_delay = PhaseDelayReset;
  logic [7:0] cfg_poll_lim = AckPollReset;
  phase_t ph = PH_IDLE;
  logic [3:0] bit_cnt = '0;
  logic [7:0] shreg = '0;
  logic [7:0] hold = '0;
  logic [7:0] polls = '0;
  logic [7:0] rx_held = '0;
  logic scl_lo = 1'b0;
  logic sda_lo = 1'b0;
  logic acked = 1'b0;
  logic ack_pend = 1'b0;
  logic done_now = 1'b0;

  result_t tick_results_q[$];
  int ticks_sent = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit steady = 1'b0;

  function automatic void enter_phase(phase_t p, logic s, logic d);
    ph = p;
    scl_lo = s;
    sda_lo = d;
    hold = (cfg_delay == 0) ? 8'd1 : cfg_delay;
  endfunction

  function automatic void end_command();
    ph = PH_IDLE;
    hold = '0;
    done_now = 1'b1;
  endfunction

  function automatic result_t predict_tick(tick_t t);
    result_t r;
    logic [7:0] lim;
    lim = (cfg_poll_lim == 0) ? 8'd1 : cfg_poll_lim;
    done_now = 1'b0;
    if (ph == PH_IDLE) begin
      if (t.cmd_valid) begin
        bit_cnt = '0;
        case (t.mode)
          MODE_START: enter_phase(PH_STA, scl_lo, 1'b1);
          MODE_WRITE: begin
            shreg = t.tx_byte;
            enter_phase(PH_WBIT, 1'b1, ~shreg[7]);
          end
          MODE_READ: begin
            shreg = '0;
            ack_pend = t.send_ack;
            enter_phase(PH_RPRE, 1'b1, 1'b0);
          end
          default: enter_phase(PH_SPA, 1'b1, 1'b1);
        endcase
      end
    end else if (hold > 1) begin
      hold = hold - 8'd1;
    end else begin
      hold = '0;
      case (ph)
        PH_STA: enter_phase(PH_STB, 1'b1, 1'b1);
        PH_STB: end_command();
        PH_WBIT: enter_phase(PH_WHI, 1'b0, sda_lo);
        PH_WHI: enter_phase(PH_WLO, 1'b1, sda_lo);
        PH_WLO: begin
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= BitsPerByte) begin
            polls = '0;
            enter_phase(PH_WACK, 1'b0, 1'b0);
          end else begin
            enter_phase(PH_WBIT, 1'b1, ~shreg[7]);
          end
        end
        PH_WACK: begin
          if (!t.sda_level) begin
            acked = 1'b1;
            enter_phase(PH_WACKL, 1'b1, 1'b0);
          end else begin
            if (polls < PollMax) polls = polls + 8'd1;
            if (polls >= lim) begin
              acked = 1'b0;
              enter_phase(PH_WACKL, 1'b1, 1'b0);
            end
          end
        end
        PH_WACKL: end_command();
        PH_RPRE: enter_phase(PH_RHI, 1'b0, 1'b0);
        PH_RHI: begin
          shreg = {shreg[6:0], t.sda_level};
          enter_phase(PH_RLO, 1'b1, 1'b0);
        end
        PH_RLO: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= BitsPerByte) enter_phase(PH_RACKH, 1'b0, ack_pend);
          else enter_phase(PH_RPRE, 1'b1, 1'b0);
        end
        PH_RACKH: enter_phase(PH_RACKL, 1'b1, sda_lo);
        PH_RACKL: begin
          rx_held = shreg;
          end_command();
        end
        PH_SPA: enter_phase(PH_SPB, 1'b0, 1'b1);
        PH_SPB: enter_phase(PH_SPC, 1'b0, 1'b0);
        default: end_command();
      endcase
    end
    r.scl_drive_low = scl_lo;
    r.sda_drive_low = sda_lo;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = done_now;
    r.ack_received = acked;
    r.rx_byte = rx_held;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic sda_drive_t pick_pol();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return SDA_RANDOM;
    if (r < 8) return SDA_HIGH;
    return SDA_LOW;
  endfunction

  function automatic tick_t noise_tick(sda_drive_t pol);
    tick_t t;
    case (pol)
      SDA_HIGH: t.sda_level = 1'b1;
      SDA_LOW: t.sda_level = 1'b0;
      default: t.sda_level = 1'($urandom_range(0, 1));
    endcase
    t.cmd_valid = 1'($urandom_range(0, 1));
    t.mode = 2'($urandom_range(0, 3));
    t.tx_byte = 8'($urandom_range(0, 255));
    t.send_ack = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.payload <= t;
    do @(posedge clk); while (!tick_ch.ready);
    tick_results_q.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  // issue one command on an idle engine and clock it through to the end
  task automatic do_cmd(input mode_t m, input logic [7:0] tx, input logic sack,
                        input sda_drive_t pol);
    tick_t t;
    t = noise_tick(pol);
    t.cmd_valid = 1'b1;
    t.mode = m;
    t.tx_byte = tx;
    t.send_ack = sack;
    send_tick(t);
    while (ph != PH_IDLE) send_tick(noise_tick(pol));
  endtask

  task automatic idle_ticks(input int n);
    tick_t t;
    repeat (n) begin
      t = noise_tick(SDA_RANDOM);
      t.cmd_valid = 1'b0;
      send_tick(t);
    end
  endtask

  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] delay, input logic [7:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= REG_PHASE_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_delay = delay;
    cfg_index <= REG_ACK_POLL;
    cfg_data <= limit;
    @(posedge clk);
    cfg_poll_lim = limit;
    cfg_we <= 1'b0;
  endtask

  // start, address, up to three data bytes, stop
  task automatic run_sequence();
    int n;
    int i;
    n = $urandom_range(0, 3);
    do_cmd(MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM);
    do_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_pol());
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        do_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               pick_pol());
      else
        do_cmd(MODE_READ, 8'($urandom_range(0, 255)), (i != n - 1), pick_pol());
    end
    do_cmd(MODE_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM);
  endtask

  task automatic run_traffic(input int count);
    int target;
    int r;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) run_sequence();
      else if (r < 9)
        do_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), pick_pol());
      else idle_ticks($urandom_range(1, 4));
    end
  endtask

  task automatic test_directed_commands();
    idle_ticks(3);
    do_cmd(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
    do_cmd(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
    do_cmd(MODE_WRITE, 8'hFF, 1'b0, SDA_LOW);
    do_cmd(MODE_WRITE, 8'h00, 1'b1, SDA_HIGH);
    do_cmd(MODE_READ, 8'h00, 1'b1, SDA_HIGH);
    do_cmd(MODE_READ, 8'hFF, 1'b0, SDA_LOW);
    idle_ticks(2);
    do_cmd(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
    do_cmd(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
    do_cmd(MODE_READ, 8'h5A, 1'b1, SDA_RANDOM);
    do_cmd(MODE_STOP, 8'h00, 1'b1, SDA_RANDOM);
  endtask

  task automatic test_register_extremes();
    settle();
    set_regs(8'd0, 8'd0);
    run_sequence();
    do_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_HIGH);
    settle();
    set_regs(8'd1, 8'd255);
    do_cmd(MODE_WRITE, 8'h3C, 1'b0, SDA_HIGH);
    do_cmd(MODE_READ, 8'h00, 1'b0, SDA_RANDOM);
    settle();
    set_regs(8'd1, 8'd1);
    do_cmd(MODE_WRITE, 8'hC3, 1'b0, SDA_HIGH);
  endtask

  task automatic test_backpressure();
    settle();
    set_regs(8'd1, 8'd8);
    steady = 1'b1;
    rx_hold = PressureHold;
    run_traffic(100);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    logic [7:0] delay;
    start = ticks_sent;
    while (ticks_sent - start < RandomTicks) begin
      settle();
      r = $urandom_range(0, 7);
      if (r == 0) delay = 8'd0;
      else if (r == 1) delay = 8'($urandom_range(4, 6));
      else delay = 8'($urandom_range(1, 3));
      set_regs(delay, 8'($urandom_range(0, 255)));
      steady = ($urandom_range(0, 3) == 0);
      run_traffic(50);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PHASE_DELAY;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.payload = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // result sink: random gaps, plus a long hold-off on request
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (tick_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: unexpected result transaction", $time);
      end else begin
        want = tick_results_q.pop_front();
        if (got.scl_drive_low !== want.scl_drive_low ||
            got.sda_drive_low !== want.sda_drive_low ||
            got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res ||
            got.ack_received !== want.ack_received ||
            got.rx_byte !== want.rx_byte) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: mismatch scl/sda/busy/done/ack/rx exp %b%b%b%b%b %h got %b%b%b%b%b %h",
                     $time, want.scl_drive_low, want.sda_drive_low, want.busy_res,
                     want.done_res, want.ack_received, want.rx_byte,
                     got.scl_drive_low, got.sda_drive_low, got.busy_res,
                     got.done_res, got.ack_received, got.rx_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("tb: FAIL");
    $finish;
  end

endmodule
